// File: sv/grid_maze_backtracker_macros.svh
// Assertion macros used by the maze carver's port checker
`ifndef GRID_MAZE_BACKTRACKER_MACROS_SVH
`define GRID_MAZE_BACKTRACKER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define GMB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define GMB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/gmb_pkg.sv
// Shared types, result codes and the microcode table of the maze carver
package gmb_pkg;

    // Result kinds carried on the result channel's tuser
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_START = 2'd0;
    localparam kind_t KIND_CARVE = 2'd1;
    localparam kind_t KIND_BACK  = 2'd2;
    localparam kind_t KIND_EMPTY = 2'd3;

    // Request type on the input channel's tuser
    localparam logic REQ_START = 1'b0;

    // Neighbour directions, in search order
    typedef enum logic [1:0] {
        DIR_LEFT,
        DIR_RIGHT,
        DIR_UP,
        DIR_DOWN
    } dir_t;

    // Microcode addresses
    localparam int UA_W = 5;
    typedef logic [UA_W-1:0] uaddr_t;
    localparam uaddr_t UA_FETCH    = 5'd0;
    localparam uaddr_t UA_DISPATCH = 5'd1;
    localparam uaddr_t UA_POP      = 5'd2;
    localparam uaddr_t UA_CUR      = 5'd3;
    localparam uaddr_t UA_RD_MID   = 5'd4;
    localparam uaddr_t UA_RD_UP    = 5'd5;
    localparam uaddr_t UA_RD_DN    = 5'd6;
    localparam uaddr_t UA_LAT_DN   = 5'd7;
    localparam uaddr_t UA_PICK     = 5'd8;
    localparam uaddr_t UA_WR_WALL  = 5'd9;
    localparam uaddr_t UA_WR_NB    = 5'd10;
    localparam uaddr_t UA_EM_CARVE = 5'd11;
    localparam uaddr_t UA_BACK     = 5'd12;
    localparam uaddr_t UA_EM_BACK  = 5'd13;
    localparam uaddr_t UA_EM_EMPTY = 5'd14;
    localparam uaddr_t UA_CLR_INIT = 5'd15;
    localparam uaddr_t UA_CLR      = 5'd16;
    localparam uaddr_t UA_SEED     = 5'd17;
    localparam uaddr_t UA_EM_START = 5'd18;

    // Jump conditions
    typedef enum logic [2:0] {
        JC_NONE,
        JC_ALWAYS,
        JC_NO_VALID,
        JC_START,
        JC_SP_ZERO,
        JC_CLR_MORE,
        JC_NO_CAND
    } jcond_t;

    // Open-map row read select
    typedef enum logic [1:0] {
        MR_NONE,
        MR_CUR,
        MR_UP,
        MR_DN
    } map_rd_t;

    // Open-map read data capture
    typedef enum logic [1:0] {
        ML_NONE,
        ML_MID,
        ML_UP,
        ML_DN
    } map_lat_t;

    // Open-map write select
    typedef enum logic [2:0] {
        MW_NONE,
        MW_CLEAR,
        MW_WALL,
        MW_NB,
        MW_SEED
    } map_wr_t;

    // Stack pointer operation
    typedef enum logic [1:0] {
        SP_NONE,
        SP_DEC,
        SP_PUSH,
        SP_SEED
    } sp_op_t;

    // Result emission
    typedef enum logic [2:0] {
        EM_NONE,
        EM_START,
        EM_CARVE,
        EM_BACK,
        EM_EMPTY
    } emit_t;

    // One control word
    typedef struct packed {
        logic     in_ld;
        logic     stk_rd;
        logic     cur_ld;
        logic     clr_rst;
        logic     cand_ld;
        map_rd_t  map_rd;
        map_lat_t map_lat;
        map_wr_t  map_wr;
        sp_op_t   sp_op;
        emit_t    emit;
        jcond_t   jcond;
        uaddr_t   jtarget;
    } ucode_t;

    localparam ucode_t UCODE_NOP = '{
        in_ld:   1'b0,
        stk_rd:  1'b0,
        cur_ld:  1'b0,
        clr_rst: 1'b0,
        cand_ld: 1'b0,
        map_rd:  MR_NONE,
        map_lat: ML_NONE,
        map_wr:  MW_NONE,
        sp_op:   SP_NONE,
        emit:    EM_NONE,
        jcond:   JC_NONE,
        jtarget: UA_FETCH
    };

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic req_start;
        logic sp_zero;
        logic clr_last;
        logic no_cand;
        logic out_busy;
    } dp_status_t;

    // Control store
    function automatic ucode_t ucode_rom(input uaddr_t addr);
        ucode_t w;
        w = UCODE_NOP;
        unique case (addr)
            UA_FETCH: begin
                w.in_ld   = 1'b1;
                w.jcond   = JC_NO_VALID;
                w.jtarget = UA_FETCH;
            end
            UA_DISPATCH: begin
                w.jcond   = JC_START;
                w.jtarget = UA_CLR_INIT;
            end
            UA_POP: begin
                w.stk_rd  = 1'b1;
                w.jcond   = JC_SP_ZERO;
                w.jtarget = UA_EM_EMPTY;
            end
            UA_CUR: begin
                w.cur_ld = 1'b1;
            end
            UA_RD_MID: begin
                w.map_rd = MR_CUR;
            end
            UA_RD_UP: begin
                w.map_lat = ML_MID;
                w.map_rd  = MR_UP;
            end
            UA_RD_DN: begin
                w.map_lat = ML_UP;
                w.map_rd  = MR_DN;
            end
            UA_LAT_DN: begin
                w.map_lat = ML_DN;
            end
            UA_PICK: begin
                w.cand_ld = 1'b1;
                w.jcond   = JC_NO_CAND;
                w.jtarget = UA_BACK;
            end
            UA_WR_WALL: begin
                w.map_wr = MW_WALL;
            end
            UA_WR_NB: begin
                w.map_wr = MW_NB;
                w.sp_op  = SP_PUSH;
            end
            UA_EM_CARVE: begin
                w.emit    = EM_CARVE;
                w.jcond   = JC_ALWAYS;
                w.jtarget = UA_FETCH;
            end
            UA_BACK: begin
                w.sp_op = SP_DEC;
            end
            UA_EM_BACK: begin
                w.emit    = EM_BACK;
                w.jcond   = JC_ALWAYS;
                w.jtarget = UA_FETCH;
            end
            UA_EM_EMPTY: begin
                w.emit    = EM_EMPTY;
                w.jcond   = JC_ALWAYS;
                w.jtarget = UA_FETCH;
            end
            UA_CLR_INIT: begin
                w.clr_rst = 1'b1;
            end
            UA_CLR: begin
                w.map_wr  = MW_CLEAR;
                w.jcond   = JC_CLR_MORE;
                w.jtarget = UA_CLR;
            end
            UA_SEED: begin
                w.map_wr = MW_SEED;
                w.sp_op  = SP_SEED;
            end
            UA_EM_START: begin
                w.emit    = EM_START;
                w.jcond   = JC_ALWAYS;
                w.jtarget = UA_FETCH;
            end
            default: begin
                w.jcond   = JC_ALWAYS;
                w.jtarget = UA_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

// File: sv/gmb_map_mem.sv
// Open map: one row of cells per word, bit-masked writes, registered read
module gmb_map_mem #(
    parameter int ROWS = 64,
    parameter int COLS = 64
) (
    input  logic                    aclk,
    input  logic                    we,
    input  logic [$clog2(ROWS)-1:0] waddr,
    input  logic [COLS-1:0]         wmask,
    input  logic                    wbit,
    input  logic                    re,
    input  logic [$clog2(ROWS)-1:0] raddr,
    output logic [COLS-1:0]         rdata
);

    logic [COLS-1:0] mem [ROWS];
    logic [COLS-1:0] rdata_reg;

    // Write the masked bits of one row, read one row
    always_ff @(posedge aclk) begin
        if (we) begin
            for (int i = 0; i < COLS; i++) begin
                if (wmask[i]) begin
                    mem[waddr][i] <= wbit;
                end
            end
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/gmb_stack_mem.sv
// Cell stack: one write port, one registered read port
module gmb_stack_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 12
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/gmb_seq.sv
// Microcode sequencer: step counter, control store fetch and conditional jumps
module gmb_seq
    import gmb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  dp_status_t st,
    output ucode_t     cw
);

    uaddr_t upc_reg;
    uaddr_t upc_next;
    ucode_t word;
    logic   taken;
    logic   stall;

    // Fetch the control word, evaluate the jump, hold on a blocked result
    always_comb begin
        word  = ucode_rom(upc_reg);
        stall = (word.emit != EM_NONE) && st.out_busy;
        unique case (word.jcond)
            JC_NONE:     taken = 1'b0;
            JC_ALWAYS:   taken = 1'b1;
            JC_NO_VALID: taken = !st.in_valid;
            JC_START:    taken = st.req_start;
            JC_SP_ZERO:  taken = st.sp_zero;
            JC_CLR_MORE: taken = !st.clr_last;
            JC_NO_CAND:  taken = st.no_cand;
            default:     taken = 1'b0;
        endcase
        priority if (stall) begin
            upc_next = upc_reg;
        end else if (taken) begin
            upc_next = word.jtarget;
        end else begin
            upc_next = upc_reg + 1'b1;
        end
        cw = stall ? UCODE_NOP : word;
    end

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UA_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

// File: sv/gmb_dp.sv
// Datapath: stack pointer, current cell, neighbour search, map and stack ports, result register
module gmb_dp
    import gmb_pkg::*;
#(
    parameter int MAX_SIDE    = 64,
    parameter int STACK_DEPTH = 1024
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  ucode_t     cw,
    input  logic [6:0] grid_w,
    input  logic [6:0] grid_h,
    input  logic       s_valid,
    input  logic       s_req,
    input  logic [7:0] s_pick,
    input  logic       m_ready,
    output dp_status_t st,
    output logic       m_valid,
    output kind_t      m_kind,
    output logic [5:0] m_wall_x,
    output logic [5:0] m_wall_y,
    output logic [5:0] m_cell_x,
    output logic [5:0] m_cell_y,
    output logic       m_done
);

    localparam int CW  = $clog2(MAX_SIDE);
    localparam int LW  = CW + 2;
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int EW  = 2 * CW;

    localparam logic [8:0]          SIDE_MAX = 9'(MAX_SIDE);
    localparam logic [SPW-1:0]      SP_FULL  = SPW'(STACK_DEPTH);
    localparam logic [CW-1:0]       CLR_LAST = CW'(MAX_SIDE - 1);
    localparam logic [CW-1:0]       C_ONE    = CW'(1);
    localparam logic [CW-1:0]       C_TWO    = CW'(2);
    localparam logic [MAX_SIDE-1:0] ROW_BIT0 = {{(MAX_SIDE-1){1'b0}}, 1'b1};

    // Zero-extend or cut a coordinate to the six-bit result fields
    function automatic logic [5:0] to_out(input logic [CW-1:0] c);
        logic [CW+5:0] t;
        t = (CW+6)'(c);
        return t[5:0];
    endfunction

    // Request and walk state
    logic           req_reg;
    logic [7:0]     pick_reg;
    logic [SPW-1:0] sp_reg;
    logic [SPW-1:0] sp_next;
    logic [CW-1:0]  cur_x_reg;
    logic [CW-1:0]  cur_y_reg;
    logic           left_bit_reg;
    logic           right_bit_reg;
    logic           up_bit_reg;
    logic           dn_bit_reg;
    logic [CW-1:0]  nb_x_reg;
    logic [CW-1:0]  nb_y_reg;
    logic [CW-1:0]  wl_x_reg;
    logic [CW-1:0]  wl_y_reg;
    logic [CW-1:0]  clr_reg;

    // Result register
    logic       out_vld_reg;
    logic       out_vld_next;
    kind_t      out_kind_reg;
    kind_t      out_kind_next;
    logic [5:0] out_wx_reg;
    logic [5:0] out_wx_next;
    logic [5:0] out_wy_reg;
    logic [5:0] out_wy_next;
    logic [5:0] out_cx_reg;
    logic [5:0] out_cx_next;
    logic [5:0] out_cy_reg;
    logic [5:0] out_cy_next;
    logic       out_done_reg;
    logic       out_done_next;

    // Memory ports
    logic                stk_we;
    logic [SAW-1:0]      stk_waddr;
    logic [EW-1:0]       stk_wdata;
    logic [SAW-1:0]      stk_raddr;
    logic [EW-1:0]       stk_rdata;
    logic [SPW-1:0]      sp_dec;
    logic                map_we;
    logic [CW-1:0]       map_waddr;
    logic [MAX_SIDE-1:0] map_wmask;
    logic                map_wbit;
    logic [CW-1:0]       map_raddr;
    logic [MAX_SIDE-1:0] map_rdata;

    // Neighbour search
    logic [LW-1:0] w_cl;
    logic [LW-1:0] h_cl;
    logic [3:0]    cand_f;
    logic [2:0]    cnt;
    logic [10:0]   prod;
    logic [1:0]    idx;
    logic [2:0]    seen;
    logic          found;
    dir_t          sel;
    logic [CW-1:0] pk_x;
    logic [CW-1:0] pk_y;
    logic [CW-1:0] pw_x;
    logic [CW-1:0] pw_y;
    logic [CW-1:0] xm2;
    logic [CW-1:0] xp2;

    gmb_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (EW)
    ) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (cw.stk_rd),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    gmb_map_mem #(
        .ROWS (MAX_SIDE),
        .COLS (MAX_SIDE)
    ) u_map (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wmask (map_wmask),
        .wbit  (map_wbit),
        .re    (cw.map_rd != MR_NONE),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // Saturate the grid sizes to three up to the map side
    always_comb begin
        priority if (grid_w < 7'd3) begin
            w_cl = LW'(3);
        end else if ({2'b00, grid_w} > SIDE_MAX) begin
            w_cl = LW'(MAX_SIDE);
        end else begin
            w_cl = LW'(grid_w);
        end
        priority if (grid_h < 7'd3) begin
            h_cl = LW'(3);
        end else if ({2'b00, grid_h} > SIDE_MAX) begin
            h_cl = LW'(MAX_SIDE);
        end else begin
            h_cl = LW'(grid_h);
        end
    end

    assign xm2 = cur_x_reg - C_TWO;
    assign xp2 = cur_x_reg + C_TWO;

    // Gather wall-state neighbours and choose one by the random byte
    always_comb begin
        cand_f[0] = (cur_x_reg >= C_TWO) && !left_bit_reg;
        cand_f[1] = ((LW'(cur_x_reg) + LW'(2)) < w_cl) && !right_bit_reg;
        cand_f[2] = (cur_y_reg >= C_TWO) && !up_bit_reg;
        cand_f[3] = ((LW'(cur_y_reg) + LW'(2)) < h_cl) && !dn_bit_reg;
        cnt  = 3'(cand_f[0]) + 3'(cand_f[1]) + 3'(cand_f[2]) + 3'(cand_f[3]);
        prod = 11'(pick_reg) * 11'(cnt);
        idx  = prod[9:8];
        seen  = 3'd0;
        found = 1'b0;
        sel   = DIR_LEFT;
        for (int d = 0; d < 4; d++) begin
            if (cand_f[d]) begin
                if (!found && (seen == {1'b0, idx})) begin
                    sel   = dir_t'(d[1:0]);
                    found = 1'b1;
                end
                seen = seen + 3'd1;
            end
        end
        unique case (sel)
            DIR_LEFT: begin
                pk_x = xm2;
                pk_y = cur_y_reg;
                pw_x = cur_x_reg - C_ONE;
                pw_y = cur_y_reg;
            end
            DIR_RIGHT: begin
                pk_x = xp2;
                pk_y = cur_y_reg;
                pw_x = cur_x_reg + C_ONE;
                pw_y = cur_y_reg;
            end
            DIR_UP: begin
                pk_x = cur_x_reg;
                pk_y = cur_y_reg - C_TWO;
                pw_x = cur_x_reg;
                pw_y = cur_y_reg - C_ONE;
            end
            DIR_DOWN: begin
                pk_x = cur_x_reg;
                pk_y = cur_y_reg + C_TWO;
                pw_x = cur_x_reg;
                pw_y = cur_y_reg + C_ONE;
            end
            default: begin
                pk_x = cur_x_reg;
                pk_y = cur_y_reg;
                pw_x = cur_x_reg;
                pw_y = cur_y_reg;
            end
        endcase
    end

    // Stack pointer and stack port
    always_comb begin
        sp_dec = sp_reg - SPW'(1);
        unique case (cw.sp_op)
            SP_NONE: sp_next = sp_reg;
            SP_DEC:  sp_next = sp_dec;
            SP_PUSH: sp_next = (sp_reg < SP_FULL) ? sp_reg + SPW'(1) : sp_reg;
            SP_SEED: sp_next = SPW'(1);
            default: sp_next = sp_reg;
        endcase
        stk_raddr = sp_dec[SAW-1:0];
        stk_we    = ((cw.sp_op == SP_PUSH) && (sp_reg < SP_FULL)) || (cw.sp_op == SP_SEED);
        if (cw.sp_op == SP_SEED) begin
            stk_waddr = '0;
            stk_wdata = {C_ONE, C_ONE};
        end else begin
            stk_waddr = sp_reg[SAW-1:0];
            stk_wdata = {nb_y_reg, nb_x_reg};
        end
    end

    // Open-map ports
    always_comb begin
        unique case (cw.map_rd)
            MR_UP:   map_raddr = cur_y_reg - C_TWO;
            MR_DN:   map_raddr = cur_y_reg + C_TWO;
            default: map_raddr = cur_y_reg;
        endcase
        map_we = (cw.map_wr != MW_NONE);
        unique case (cw.map_wr)
            MW_CLEAR: begin
                map_waddr = clr_reg;
                map_wmask = '1;
                map_wbit  = 1'b0;
            end
            MW_WALL: begin
                map_waddr = wl_y_reg;
                map_wmask = ROW_BIT0 << wl_x_reg;
                map_wbit  = 1'b1;
            end
            MW_NB: begin
                map_waddr = nb_y_reg;
                map_wmask = ROW_BIT0 << nb_x_reg;
                map_wbit  = 1'b1;
            end
            MW_SEED: begin
                map_waddr = C_ONE;
                map_wmask = ROW_BIT0 << C_ONE;
                map_wbit  = 1'b1;
            end
            default: begin
                map_waddr = clr_reg;
                map_wmask = '0;
                map_wbit  = 1'b0;
            end
        endcase
    end

    // Result register next values
    always_comb begin
        out_kind_next = out_kind_reg;
        out_wx_next   = out_wx_reg;
        out_wy_next   = out_wy_reg;
        out_cx_next   = out_cx_reg;
        out_cy_next   = out_cy_reg;
        out_done_next = out_done_reg;
        unique case (cw.emit)
            EM_START: begin
                out_kind_next = KIND_START;
                out_wx_next   = to_out(C_ONE);
                out_wy_next   = to_out(C_ONE);
                out_cx_next   = to_out(C_ONE);
                out_cy_next   = to_out(C_ONE);
                out_done_next = 1'b0;
            end
            EM_CARVE: begin
                out_kind_next = KIND_CARVE;
                out_wx_next   = to_out(wl_x_reg);
                out_wy_next   = to_out(wl_y_reg);
                out_cx_next   = to_out(nb_x_reg);
                out_cy_next   = to_out(nb_y_reg);
                out_done_next = 1'b0;
            end
            EM_BACK: begin
                out_kind_next = KIND_BACK;
                out_wx_next   = to_out(cur_x_reg);
                out_wy_next   = to_out(cur_y_reg);
                out_cx_next   = to_out(cur_x_reg);
                out_cy_next   = to_out(cur_y_reg);
                out_done_next = (sp_reg == '0);
            end
            EM_EMPTY: begin
                out_kind_next = KIND_EMPTY;
                out_wx_next   = '0;
                out_wy_next   = '0;
                out_cx_next   = '0;
                out_cy_next   = '0;
                out_done_next = 1'b1;
            end
            default: begin
                out_kind_next = out_kind_reg;
            end
        endcase
        priority if (cw.emit != EM_NONE) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg      <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            sp_reg      <= sp_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cw.in_ld && s_valid) begin
            req_reg  <= s_req;
            pick_reg <= s_pick;
        end
        if (cw.cur_ld) begin
            cur_x_reg <= stk_rdata[CW-1:0];
            cur_y_reg <= stk_rdata[EW-1:CW];
        end
        unique case (cw.map_lat)
            ML_MID: begin
                left_bit_reg  <= map_rdata[xm2];
                right_bit_reg <= map_rdata[xp2];
            end
            ML_UP: begin
                up_bit_reg <= map_rdata[cur_x_reg];
            end
            ML_DN: begin
                dn_bit_reg <= map_rdata[cur_x_reg];
            end
            default: begin
            end
        endcase
        if (cw.cand_ld) begin
            nb_x_reg <= pk_x;
            nb_y_reg <= pk_y;
            wl_x_reg <= pw_x;
            wl_y_reg <= pw_y;
        end
        if (cw.clr_rst) begin
            clr_reg <= '0;
        end else if (cw.map_wr == MW_CLEAR) begin
            clr_reg <= clr_reg + C_ONE;
        end
        out_kind_reg <= out_kind_next;
        out_wx_reg   <= out_wx_next;
        out_wy_reg   <= out_wy_next;
        out_cx_reg   <= out_cx_next;
        out_cy_reg   <= out_cy_next;
        out_done_reg <= out_done_next;
    end

    // Status to the sequencer
    always_comb begin
        st.in_valid  = s_valid;
        st.req_start = (req_reg == REQ_START);
        st.sp_zero   = (sp_reg == '0);
        st.clr_last  = (clr_reg == CLR_LAST);
        st.no_cand   = (cnt == 3'd0);
        st.out_busy  = out_vld_reg && !m_ready;
    end

    assign m_valid  = out_vld_reg;
    assign m_kind   = out_kind_reg;
    assign m_wall_x = out_wx_reg;
    assign m_wall_y = out_wy_reg;
    assign m_cell_x = out_cx_reg;
    assign m_cell_y = out_cy_reg;
    assign m_done   = out_done_reg;

endmodule

// File: sv/grid_maze_backtracker.sv
// Top level of the recursive-backtracker maze carver
//
//  Channel  Direction  Ports                         Contents
//  s_       in         tvalid tready tdata tuser     request: start or one carving step
//  m_       out        tvalid tready tdata tuser     one result per request
//                      tlast
//  apb      in/out     psel penable pwrite paddr     grid width (0x0), grid height (0x4)
//                      pwdata prdata pready
//
//  A carving or backtracking step reads three rows of the open map through its single
//  port, and a start first clears the open map row by row. A new request is taken only
//  after the last one's result is emitted. Reset empties the stack and sets both grid
//  sizes to 63. A stalled result holds the sequencer at its emit step.
module grid_maze_backtracker
    import gmb_pkg::*;
#(
    parameter int MAX_SIDE    = 64,
    parameter int STACK_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rand_pick
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [5:0] wall_x, [11:6] wall_y, [17:12] cell_x, [23:18] cell_y
    output logic [1:0]  m_tuser,   // [1:0] step_kind
    output logic        m_tlast,   // maze_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_GRID_W = 1'b0;
    localparam logic REG_GRID_H = 1'b1;

    logic [6:0] gw_reg;
    logic [6:0] gh_reg;
    logic       cfg_wr;
    ucode_t     cw;
    dp_status_t st;
    logic [5:0] wall_x;
    logic [5:0] wall_y;
    logic [5:0] cell_x;
    logic [5:0] cell_y;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gw_reg <= 7'd63;
            gh_reg <= 7'd63;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_GRID_W) begin
                gw_reg <= pwdata[6:0];
            end else begin
                gh_reg <= pwdata[6:0];
            end
        end
    end

    assign prdata = {25'd0, (paddr[2] == REG_GRID_H) ? gh_reg : gw_reg};

    gmb_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .st      (st),
        .cw      (cw)
    );

    gmb_dp #(
        .MAX_SIDE    (MAX_SIDE),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cw       (cw),
        .grid_w   (gw_reg),
        .grid_h   (gh_reg),
        .s_valid  (s_tvalid),
        .s_req    (s_tuser),
        .s_pick   (s_tdata),
        .m_ready  (m_tready),
        .st       (st),
        .m_valid  (m_tvalid),
        .m_kind   (m_tuser),
        .m_wall_x (wall_x),
        .m_wall_y (wall_y),
        .m_cell_x (cell_x),
        .m_cell_y (cell_y),
        .m_done   (m_tlast)
    );

    // Accept a request only at the fetch step
    assign s_tready = cw.in_ld;
    assign m_tdata  = {cell_y, cell_x, wall_y, wall_x};

endmodule

// File: sv/gmb_checker.sv
// Port-level checks on the maze carver's result channel, bound to the top level
`include "grid_maze_backtracker_macros.svh"

module gmb_checker
    import gmb_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // Start result: wall and cell both at column 1, row 1
    localparam logic [23:0] START_DATA = {6'd1, 6'd1, 6'd1, 6'd1};

    // Hold a stalled result
    `GMB_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `GMB_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

    // Empty-stack result carries zero coordinates and reports the maze done
    `GMB_ASSERT_NOW(a_empty_shape, aclk, aresetn, m_tvalid && (m_tuser == KIND_EMPTY), m_tlast && (m_tdata == 24'd0), "empty-stack result malformed")

    // Start result opens the seed cell with a non-empty stack
    `GMB_ASSERT_NOW(a_start_shape, aclk, aresetn, m_tvalid && (m_tuser == KIND_START), !m_tlast && (m_tdata == START_DATA), "start result malformed")

    // A carve always leaves cells on the stack
    `GMB_ASSERT_NOW(a_carve_open, aclk, aresetn, m_tvalid && (m_tuser == KIND_CARVE), !m_tlast, "carve reported an empty stack")

endmodule

bind grid_maze_backtracker gmb_checker u_gmb_checker (.*);

// File: sim/grid_maze_checker.sv
// Result checker for the maze carver: predicts each result and compares it
`timescale 1ns / 1ps

module grid_maze_checker
    import gmb_pkg::*;
#(
    parameter int         MAX_SIDE    = 64,
    parameter int         STACK_DEPTH = 1024,
    parameter logic [2:0] WIDTH_ADDR  = 3'd0,
    parameter logic [2:0] HEIGHT_ADDR = 3'd4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rand_pick
    input  logic        s_tuser,   // [0] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [5:0] wall_x, [11:6] wall_y, [17:12] cell_x, [23:18] cell_y
    input  logic [1:0]  m_tuser,   // [1:0] step_kind
    input  logic        m_tlast,   // maze_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending_results
);

    localparam int         MIN_SIDE   = 3;
    localparam logic [6:0] RESET_SIDE = 7'd63;

    typedef struct packed {
        kind_t      kind;
        logic [5:0] wall_x;
        logic [5:0] wall_y;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic       done;
    } carve_result_t;

    // Shadow of the carver: open cells by row, cell stack and grid sizes
    logic [MAX_SIDE-1:0] open_rows [MAX_SIDE];
    logic [5:0]          stack_x [STACK_DEPTH];
    logic [5:0]          stack_y [STACK_DEPTH];
    int unsigned         stack_depth;
    logic [6:0]          width_reg;
    logic [6:0]          height_reg;
    carve_result_t       awaited_results [$];

    function automatic int unsigned side_limit(input logic [6:0] v);
        if (v < MIN_SIDE)
            return MIN_SIDE;
        if (v > MAX_SIDE)
            return MAX_SIDE;
        return 32'(v);
    endfunction

    function automatic void clear_map();
        for (int i = 0; i < MAX_SIDE; i++)
            open_rows[i] = '0;
    endfunction

    // Apply one request to the shadow state and return the result it must cause
    function automatic carve_result_t carve_step(input logic req, input logic [7:0] pick);
        carve_result_t r;
        int unsigned   w, h, cx, cy, n, sel, nx, ny, wx, wy;
        int unsigned   cand_x [4];
        int unsigned   cand_y [4];
        r = '0;
        n = 0;
        w = side_limit(width_reg);
        h = side_limit(height_reg);

        // Start: fresh map with only the corner cell open and stacked
        if (req == REQ_START) begin
            clear_map();
            open_rows[1][1] = 1'b1;
            stack_x[0] = 6'd1;
            stack_y[0] = 6'd1;
            stack_depth = 1;
            r.kind   = KIND_START;
            r.wall_x = 6'd1;
            r.wall_y = 6'd1;
            r.cell_x = 6'd1;
            r.cell_y = 6'd1;
            return r;
        end

        // Step on an empty stack changes nothing
        if (stack_depth == 0) begin
            r.kind = KIND_EMPTY;
            r.done = 1'b1;
            return r;
        end

        stack_depth--;
        cx = 32'(stack_x[stack_depth]);
        cy = 32'(stack_y[stack_depth]);

        // Gather closed cells two away: left, right, up, down
        if (cx >= 2 && !open_rows[cy][cx-2]) begin
            cand_x[n] = cx - 2; cand_y[n] = cy; n++;
        end
        if (cx + 2 < w && !open_rows[cy][cx+2]) begin
            cand_x[n] = cx + 2; cand_y[n] = cy; n++;
        end
        if (cy >= 2 && !open_rows[cy-2][cx]) begin
            cand_x[n] = cx; cand_y[n] = cy - 2; n++;
        end
        if (cy + 2 < h && !open_rows[cy+2][cx]) begin
            cand_x[n] = cx; cand_y[n] = cy + 2; n++;
        end

        if (n == 0) begin
            r.kind   = KIND_BACK;
            r.wall_x = cx[5:0];
            r.wall_y = cy[5:0];
            r.cell_x = cx[5:0];
            r.cell_y = cy[5:0];
            r.done   = (stack_depth == 0);
            return r;
        end

        // Carve towards the chosen neighbour; drop its push when the stack is full
        sel = ((int'(pick) * n) >> 8) & 3;
        nx = cand_x[sel];
        ny = cand_y[sel];
        wx = (cx + nx) >> 1;
        wy = (cy + ny) >> 1;
        stack_x[stack_depth] = cx[5:0];
        stack_y[stack_depth] = cy[5:0];
        stack_depth++;
        open_rows[wy][wx] = 1'b1;
        open_rows[ny][nx] = 1'b1;
        if (stack_depth < STACK_DEPTH) begin
            stack_x[stack_depth] = nx[5:0];
            stack_y[stack_depth] = ny[5:0];
            stack_depth++;
        end
        r.kind   = KIND_CARVE;
        r.wall_x = wx[5:0];
        r.wall_y = wy[5:0];
        r.cell_x = nx[5:0];
        r.cell_y = ny[5:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count = fail_count + 1;
        end
    endfunction

    // Track register writes, requests and results at each rising edge
    always @(posedge aclk) begin : monitor
        carve_result_t want;
        if (!aresetn) begin
            clear_map();
            stack_depth = 0;
            width_reg   = RESET_SIDE;
            height_reg  = RESET_SIDE;
            awaited_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == WIDTH_ADDR)
                    width_reg = pwdata[6:0];
                else if (paddr == HEIGHT_ADDR)
                    height_reg = pwdata[6:0];
            end

            // Compare a delivered result with the oldest outstanding one
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d data %h",
                             $time, m_tuser, m_tdata);
                    fail_count = fail_count + 1;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("step_kind", 32'(want.kind), 32'(m_tuser));
                    check_field("wall_x", 32'(want.wall_x), 32'(m_tdata[5:0]));
                    check_field("wall_y", 32'(want.wall_y), 32'(m_tdata[11:6]));
                    check_field("cell_x", 32'(want.cell_x), 32'(m_tdata[17:12]));
                    check_field("cell_y", 32'(want.cell_y), 32'(m_tdata[23:18]));
                    check_field("maze_done", 32'(want.done), 32'(m_tlast));
                end
            end

            // Queue the result this request must cause
            if (s_tvalid && s_tready)
                awaited_results = {awaited_results, carve_step(s_tuser, s_tdata)};
        end
        pending_results = awaited_results.size();
    end

endmodule

// File: sim/grid_maze_backtracker_tb.sv
// Testbench top for the maze carver: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps

module grid_maze_backtracker_tb;
    import gmb_pkg::*;

    localparam int         MAX_SIDE      = 64;
    localparam int         STACK_DEPTH   = 1024;
    localparam logic [2:0] WIDTH_ADDR    = 3'd0;
    localparam logic [2:0] HEIGHT_ADDR   = 3'd4;
    localparam logic       REQ_STEP      = ~REQ_START;
    localparam int         RANDOM_ITEMS  = 650;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         DRAIN_CYCLES  = MAX_SIDE + 16;
    localparam int         RUN_LIMIT_NS  = 2_000_000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] rand_pick
    logic        s_tuser;   // [0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // [5:0] wall_x, [11:6] wall_y, [17:12] cell_x, [23:18] cell_y
    logic [1:0]  m_tuser;   // [1:0] step_kind
    logic        m_tlast;   // maze_done
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending_results;
    int burst_left;
    int sent;
    int stall_mode;
    int stall_left;
    int ready_phase;

    grid_maze_backtracker #(
        .MAX_SIDE    (MAX_SIDE),
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    grid_maze_checker #(
        .MAX_SIDE    (MAX_SIDE),
        .STACK_DEPTH (STACK_DEPTH),
        .WIDTH_ADDR  (WIDTH_ADDR),
        .HEIGHT_ADDR (HEIGHT_ADDR)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always #2 aclk = ~aclk;

    // Stall the result side: always ready, coin toss, one in three, or mostly stalled
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        ready_phase++;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (ready_phase % 3 == 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // End the run if it hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

    // Offer one request in bursts with random gaps; return once it is taken
    task automatic issue_request(input logic req, input logic [7:0] pick);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom_range(0, 255));
            end
            burst_left = $urandom_range(1, 20);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= pick;
        do
            @(posedge aclk);
        while (!s_tready);
        burst_left--;
        sent++;
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [6:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= ($urandom & ~32'h7F) | 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold the input side, wait for all results, then set both sizes
    task automatic set_grid_size(input logic [6:0] cols, input logic [6:0] rows);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        apb_write(WIDTH_ADDR, cols);
        apb_write(HEIGHT_ADDR, rows);
    endtask

    function automatic int usable_side(input int v);
        if (v < 3)
            return 3;
        if (v > MAX_SIDE)
            return MAX_SIDE;
        return v;
    endfunction

    initial begin
        int          cols, rows, steps, cap;
        logic [7:0]  pick;
        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = REQ_START;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = WIDTH_ADDR;
        pwdata      = '0;
        burst_left  = 0;
        sent        = 0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Steps on an empty stack straight after reset
        issue_request(REQ_STEP, 8'h00);
        issue_request(REQ_STEP, 8'hFF);
        // Carve a few cells on the reset grid, then restart mid-maze
        issue_request(REQ_START, 8'hFF);
        issue_request(REQ_STEP, 8'h00);
        issue_request(REQ_STEP, 8'hFF);
        issue_request(REQ_STEP, 8'h80);
        issue_request(REQ_STEP, 8'h01);
        issue_request(REQ_START, 8'h00);
        issue_request(REQ_STEP, 8'hAA);
        // Shrink below the minimum mid-maze; then a one-cell maze ends at once
        set_grid_size(7'd0, 7'd2);
        issue_request(REQ_STEP, 8'h55);
        issue_request(REQ_START, 8'h7F);
        issue_request(REQ_STEP, 8'hFF);
        issue_request(REQ_STEP, 8'h00);
        // Sizes above the maximum saturate
        set_grid_size(7'd127, 7'd65);
        issue_request(REQ_START, 8'h00);
        issue_request(REQ_STEP, 8'hFF);
        issue_request(REQ_STEP, 8'h55);
        issue_request(REQ_STEP, 8'h00);
        issue_request(REQ_STEP, 8'hFF);
        // Widest grid, one cell row
        set_grid_size(7'd64, 7'd3);
        issue_request(REQ_START, 8'hFF);
        repeat (4) issue_request(REQ_STEP, 8'hFF);
        // Narrow the grid under a live maze
        set_grid_size(7'd4, 7'd127);
        issue_request(REQ_STEP, 8'h00);
        issue_request(REQ_STEP, 8'hC3);

        // Random phases: mostly complete small mazes, some large or out of range
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19)) inside
                [0:13]: begin
                    cols = $urandom_range(3, 15);
                    rows = $urandom_range(3, 15);
                end
                [14:16]: begin
                    cols = $urandom_range(16, 64);
                    rows = $urandom_range(16, 64);
                end
                default: begin
                    cols = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(65, 127);
                    rows = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(65, 127);
                end
            endcase
            set_grid_size(cols[6:0], rows[6:0]);
            if ($urandom_range(0, 7) != 0)
                issue_request(REQ_START, 8'($urandom_range(0, 255)));
            steps = 2 * (usable_side(cols) / 2) * (usable_side(rows) / 2) + $urandom_range(0, 2);
            cap = $urandom_range(40, 140);
            if (steps > cap)
                steps = cap;
            for (int i = 0; i < steps && sent < RANDOM_ITEMS; i++) begin
                case ($urandom_range(0, 9))
                    0: pick = 8'h00;
                    1: pick = 8'hFF;
                    default: pick = 8'($urandom_range(0, 255));
                endcase
                // Occasional restart in the middle of a maze
                if ($urandom_range(0, 39) == 0)
                    issue_request(REQ_START, pick);
                else
                    issue_request(REQ_STEP, pick);
            end
        end

        // Drain and give the verdict
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending_results == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
